### sv/rpn_pkg.sv
// Shared types, opcodes, status codes and arithmetic helpers for the RPN evaluator.
// No dependencies; the evaluator, datapath and controller refer to this package by scoped names.
package rpn_pkg;

    localparam int PROGRAM_DEPTH_DEF = 64;
    localparam int STACK_DEPTH_DEF   = 32;
    localparam int CORDIC_STEPS      = 30;
    localparam int DIV_STEPS         = 48;
    localparam int CNT_W             = 6;

    localparam logic [3:0] OP_PUSHX = 4'd0;
    localparam logic [3:0] OP_PUSHC = 4'd1;
    localparam logic [3:0] OP_ADD   = 4'd2;
    localparam logic [3:0] OP_SUB   = 4'd3;
    localparam logic [3:0] OP_MUL   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_SIN   = 4'd6;
    localparam logic [3:0] OP_COS   = 4'd7;
    localparam logic [3:0] OP_STOP  = 4'd8;

    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_SAT    = 3'd1;
    localparam logic [2:0] ST_DIVZ   = 3'd2;
    localparam logic [2:0] ST_FAULT  = 3'd3;
    localparam logic [2:0] ST_NOSTOP = 3'd4;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] CFG_X_ORIGIN  = 2'd0;
    localparam logic [1:0] CFG_X_SPACING = 2'd1;

    localparam logic [31:0]        X_SPACING_RESET = 32'h0001_0000;
    localparam logic signed [33:0] CORDIC_GAIN     = 34'sd652032874;
    localparam logic [31:0]        HALF_PI_Q30     = 32'd1686629713;
    localparam logic [45:0]        TURNS_PER_Q16   = 46'd44798133900177;

    typedef struct packed {
        logic               command;
        logic [5:0]         slot;
        logic [3:0]         opcode;
        logic signed [31:0] literal;
        logic [11:0]        sample_index;
    } t_in;

    typedef struct packed {
        logic signed [31:0] y_value;
        logic [2:0]         status;
    } t_out;

    typedef struct packed {
        logic        hit;
        logic [31:0] val;
    } t_sat;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       start;
        logic       x_mul;
        logic       x_add;
        logic       pc_inc;
        logic       push;
        logic       push_x;
        logic       pop;
        logic       bin_add;
        logic       bin_sub;
        logic       bin_mul;
        logic       bin_div;
        logic       mul_fin;
        logic       div_step;
        logic       div_fin;
        logic       ang1;
        logic       ang2;
        logic       ang3;
        logic       ang4;
        logic       cord_step;
        logic       cord_fin;
        logic       sel_sin;
        logic [4:0] iter;
        logic       fin;
        logic [2:0] fin_kind;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [3:0] op;
        logic       lvl_lt1;
        logic       lvl_lt2;
        logic       lvl_full;
        logic       pc_end;
        logic       top_zero;
        logic       out_free;
    } t_stat;

    function automatic logic [65:0] sx66(input logic [31:0] v);
        sx66 = {{34{v[31]}}, v};
    endfunction

    // Clamp to signed 32 bits
    function automatic t_sat sat32(input logic signed [65:0] v);
        t_sat r;
        r.hit = 1'b0;
        r.val = v[31:0];
        if (v > 66'sd2147483647) begin
            r.hit = 1'b1;
            r.val = 32'h7FFF_FFFF;
        end else if (v < -66'sd2147483648) begin
            r.hit = 1'b1;
            r.val = 32'h8000_0000;
        end
        sat32 = r;
    endfunction

    // Arctangent of 2^-i in Q2.30
    function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
        case (i)
            5'd0:  atan_q30 = 34'sd843314857;
            5'd1:  atan_q30 = 34'sd497837829;
            5'd2:  atan_q30 = 34'sd263043837;
            5'd3:  atan_q30 = 34'sd133525159;
            5'd4:  atan_q30 = 34'sd67021687;
            5'd5:  atan_q30 = 34'sd33543516;
            5'd6:  atan_q30 = 34'sd16775851;
            5'd7:  atan_q30 = 34'sd8388437;
            5'd8:  atan_q30 = 34'sd4194283;
            5'd9:  atan_q30 = 34'sd2097149;
            5'd10: atan_q30 = 34'sd1048576;
            5'd11: atan_q30 = 34'sd524288;
            5'd12: atan_q30 = 34'sd262144;
            5'd13: atan_q30 = 34'sd131072;
            5'd14: atan_q30 = 34'sd65536;
            5'd15: atan_q30 = 34'sd32768;
            5'd16: atan_q30 = 34'sd16384;
            5'd17: atan_q30 = 34'sd8192;
            5'd18: atan_q30 = 34'sd4096;
            5'd19: atan_q30 = 34'sd2048;
            5'd20: atan_q30 = 34'sd1024;
            5'd21: atan_q30 = 34'sd512;
            5'd22: atan_q30 = 34'sd256;
            5'd23: atan_q30 = 34'sd128;
            5'd24: atan_q30 = 34'sd64;
            5'd25: atan_q30 = 34'sd32;
            5'd26: atan_q30 = 34'sd16;
            5'd27: atan_q30 = 34'sd8;
            5'd28: atan_q30 = 34'sd4;
            5'd29: atan_q30 = 34'sd2;
            default: atan_q30 = 34'sd0;
        endcase
    endfunction

endpackage

### sv/rpn_expression_evaluator.sv
// Load items are taken without stalling. An evaluate item first forms x, then steps through the
// tokens (push or skipped, add/sub, mul, div with a short path by zero, sin/cos, STOP) and at
// the end writes the output register (a fault or a missing STOP also ends with that write).
// One item is in work at a time; the input stalls from the cycle after an evaluate item is
// accepted until the cycle after its result is written. The token sequencer and its
// one-bit-per-cycle divider and one-rotation-per-cycle CORDIC set the rate. A finished result
// waits in an output register. Reset is synchronous, active low: clears control,
// x_origin to 0, x_spacing to 1.0. Memories are not cleared.
module rpn_expression_evaluator #(
    parameter int PROGRAM_DEPTH = rpn_pkg::PROGRAM_DEPTH_DEF,
    parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rpn_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rpn_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    rpn_pkg::t_cmd  cmd;
    rpn_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    rpn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_command  (i_in_data.command),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rpn_datapath #(
        .PROGRAM_DEPTH (PROGRAM_DEPTH),
        .STACK_DEPTH   (STACK_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

`ifndef SYNTHESIS
    // Faulted or unterminated programs return zero
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == rpn_pkg::ST_FAULT ||
                        o_out_data.status == rpn_pkg::ST_NOSTOP)
        |-> o_out_data.y_value == '0)
        else $error("fault result not zero");

    // Status stays within the defined codes
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.status <= rpn_pkg::ST_NOSTOP)
        else $error("undefined status code");

    // An accepted evaluate item keeps the input side stalled next cycle
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_data.command == rpn_pkg::CMD_EVAL
        |=> o_in_stall)
        else $error("evaluator took a new item while busy");
`endif

endmodule

### sv/rpn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/rpn_datapath.sv
// Evaluator datapath: program and stack memories, arithmetic, divider, CORDIC, output register.
// Depends on rpn_pkg and rpn_ram.
module rpn_datapath #(
    parameter int PROGRAM_DEPTH = rpn_pkg::PROGRAM_DEPTH_DEF,
    parameter int STACK_DEPTH   = rpn_pkg::STACK_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rpn_pkg::t_in  i_in_data,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  rpn_pkg::t_cmd i_cmd,
    output rpn_pkg::t_stat o_stat,
    input  logic          i_out_stall,
    output logic          o_out_valid,
    output rpn_pkg::t_out o_out_data
);

    localparam int AW  = $clog2(PROGRAM_DEPTH);
    localparam int PCW = $clog2(PROGRAM_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int LW  = $clog2(STACK_DEPTH + 2);

    logic [31:0]        r_x_origin, r_x_spacing;
    logic [PCW-1:0]     r_pc;
    logic [LW-1:0]      r_level;
    logic signed [31:0] r_top, r_x;
    logic               r_sat, r_divz;
    logic [11:0]        r_idx;
    logic signed [44:0] r_xprod;
    logic signed [63:0] r_prod;
    logic [32:0]        r_rem;
    logic [47:0]        r_quo;
    logic [31:0]        r_dvs;
    logic               r_neg;
    logic signed [55:0] r_pa, r_pb;
    logic [1:0]         r_quad;
    logic [31:0]        r_frac;
    logic signed [33:0] r_cx, r_cy, r_cz;
    logic               r_out_valid;
    rpn_pkg::t_out      r_out;

    logic [35:0]        prog_rdata;
    logic [31:0]        stk_rdata;
    logic               prog_we;
    logic [31:0]        slot_ext;
    logic [LW-1:0]      lvl_m1, lvl_m2;
    logic signed [31:0] opa, lit;
    rpn_pkg::t_sat      s_x, s_add, s_sub, s_mul;
    logic signed [63:0] mul_rnd;
    logic [32:0]        div_t;
    logic [33:0]        div_d;
    logic [31:0]        a_abs, b_abs;
    logic [63:0]        ang_u, ang_z;
    logic signed [33:0] cd_x, cd_y, cr_c, cr_s;
    logic signed [31:0] cq, sq, trig_s, trig_c;

    assign slot_ext = {26'd0, i_in_data.slot};
    assign prog_we  = i_cmd.load && (slot_ext < 32'(PROGRAM_DEPTH));
    assign lvl_m1   = r_level - LW'(1);
    assign lvl_m2   = r_level - LW'(2);

    rpn_ram #(.WIDTH(36), .DEPTH(PROGRAM_DEPTH)) u_prog (
        .i_clk   (i_clk),
        .i_we    (prog_we),
        .i_waddr (slot_ext[AW-1:0]),
        .i_wdata ({i_in_data.opcode, i_in_data.literal}),
        .i_raddr (r_pc[AW-1:0]),
        .o_rdata (prog_rdata)
    );

    rpn_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push && (r_level != '0)),
        .i_waddr (lvl_m1[SAW-1:0]),
        .i_wdata (r_top),
        .i_raddr (lvl_m2[SAW-1:0]),
        .o_rdata (stk_rdata)
    );

    assign lit = prog_rdata[31:0];
    assign opa = stk_rdata;

    // Arithmetic results
    always_comb begin
        s_x     = rpn_pkg::sat32(rpn_pkg::sx66(r_x_origin) + {{21{r_xprod[44]}}, r_xprod});
        s_add   = rpn_pkg::sat32(rpn_pkg::sx66(opa) + rpn_pkg::sx66(r_top));
        s_sub   = rpn_pkg::sat32(rpn_pkg::sx66(opa) - rpn_pkg::sx66(r_top));
        mul_rnd = (r_prod + 64'sd32768) >>> 16;
        s_mul   = rpn_pkg::sat32({{2{mul_rnd[63]}}, mul_rnd});
        a_abs   = opa[31] ? 32'(-opa) : opa;
        b_abs   = r_top[31] ? 32'(-r_top) : r_top;
        div_t   = {r_rem[31:0], r_quo[47]};
        div_d   = {1'b0, div_t} - {2'b00, r_dvs};
        ang_u   = {{8{r_pa[55]}}, r_pa} + ({{8{r_pb[55]}}, r_pb} << 23);
        ang_z   = r_frac * rpn_pkg::HALF_PI_Q30;
        cd_x    = r_cy >>> i_cmd.iter;
        cd_y    = r_cx >>> i_cmd.iter;
        cr_c    = (r_cx + 34'sd8192) >>> 14;
        cr_s    = (r_cy + 34'sd8192) >>> 14;
        cq      = cr_c[31:0];
        sq      = cr_s[31:0];
        case (r_quad)
            2'd0: begin
                trig_c = cq;
                trig_s = sq;
            end
            2'd1: begin
                trig_c = -sq;
                trig_s = cq;
            end
            2'd2: begin
                trig_c = -cq;
                trig_s = -sq;
            end
            default: begin
                trig_c = sq;
                trig_s = -cq;
            end
        endcase
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin  <= '0;
            r_x_spacing <= rpn_pkg::X_SPACING_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpn_pkg::CFG_X_ORIGIN:  r_x_origin  <= i_cfg_data;
                rpn_pkg::CFG_X_SPACING: r_x_spacing <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Evaluation control state: program counter, stack level, flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc    <= '0;
            r_level <= '0;
            r_sat   <= 1'b0;
            r_divz  <= 1'b0;
        end else begin
            if (i_cmd.start) begin
                r_pc    <= '0;
                r_level <= '0;
                r_sat   <= 1'b0;
                r_divz  <= 1'b0;
            end
            if (i_cmd.pc_inc) begin
                r_pc <= r_pc + PCW'(1);
            end
            if (i_cmd.push) begin
                r_level <= r_level + LW'(1);
            end
            if (i_cmd.pop) begin
                r_level <= lvl_m1;
            end
            if ((i_cmd.x_add && s_x.hit) || (i_cmd.bin_add && s_add.hit) ||
                (i_cmd.bin_sub && s_sub.hit) || (i_cmd.mul_fin && s_mul.hit)) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.div_fin && ((r_neg && r_quo > 48'h0000_8000_0000) ||
                                  (!r_neg && r_quo > 48'h0000_7FFF_FFFF))) begin
                r_sat <= 1'b1;
            end
            if (i_cmd.bin_div && r_top == '0) begin
                r_divz <= 1'b1;
            end
        end
    end

    // Operand values and iterative units
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_idx <= i_in_data.sample_index;
            r_top <= '0;
        end
        if (i_cmd.x_mul) begin
            r_xprod <= $signed({1'b0, r_idx}) * $signed(r_x_spacing);
        end
        if (i_cmd.x_add) begin
            r_x <= s_x.val;
        end
        if (i_cmd.push) begin
            r_top <= i_cmd.push_x ? r_x : lit;
        end
        if (i_cmd.bin_add) begin
            r_top <= s_add.val;
        end
        if (i_cmd.bin_sub) begin
            r_top <= s_sub.val;
        end
        if (i_cmd.bin_mul) begin
            r_prod <= opa * r_top;
        end
        if (i_cmd.mul_fin) begin
            r_top <= s_mul.val;
        end
        // Divider: load magnitudes; on a zero divisor also saturate the result
        if (i_cmd.bin_div) begin
            if (r_top == '0) begin
                r_top <= opa[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
            end
            r_neg <= opa[31] ^ r_top[31];
            r_quo <= {a_abs, 16'd0};
            r_rem <= '0;
            r_dvs <= b_abs;
        end
        if (i_cmd.div_step) begin
            r_rem <= div_d[33] ? div_t : div_d[32:0];
            r_quo <= {r_quo[46:0], !div_d[33]};
        end
        if (i_cmd.div_fin) begin
            if (r_neg) begin
                r_top <= (r_quo > 48'h0000_8000_0000) ? 32'sh8000_0000 : -r_quo[31:0];
            end else begin
                r_top <= (r_quo > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : r_quo[31:0];
            end
        end
        // Angle reduction to quarter turns, split product
        if (i_cmd.ang1) begin
            r_pa <= r_top * $signed({1'b0, rpn_pkg::TURNS_PER_Q16[22:0]});
        end
        if (i_cmd.ang2) begin
            r_pb <= r_top * $signed({1'b0, rpn_pkg::TURNS_PER_Q16[45:23]});
        end
        if (i_cmd.ang3) begin
            r_quad <= ang_u[63:62];
            r_frac <= ang_u[61:30];
        end
        if (i_cmd.ang4) begin
            r_cz <= {2'b00, ang_z[63:32]};
            r_cx <= rpn_pkg::CORDIC_GAIN;
            r_cy <= '0;
        end
        // One CORDIC rotation per cycle
        if (i_cmd.cord_step) begin
            if (!r_cz[33]) begin
                r_cx <= r_cx - cd_x;
                r_cy <= r_cy + cd_y;
                r_cz <= r_cz - rpn_pkg::atan_q30(i_cmd.iter);
            end else begin
                r_cx <= r_cx + cd_x;
                r_cy <= r_cy - cd_y;
                r_cz <= r_cz + rpn_pkg::atan_q30(i_cmd.iter);
            end
        end
        if (i_cmd.cord_fin) begin
            r_top <= i_cmd.sel_sin ? trig_s : trig_c;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            case (i_cmd.fin_kind)
                rpn_pkg::ST_FAULT: begin
                    r_out.y_value <= '0;
                    r_out.status  <= rpn_pkg::ST_FAULT;
                end
                rpn_pkg::ST_NOSTOP: begin
                    r_out.y_value <= '0;
                    r_out.status  <= rpn_pkg::ST_NOSTOP;
                end
                default: begin
                    r_out.y_value <= r_top;
                    r_out.status  <= r_divz ? rpn_pkg::ST_DIVZ :
                                     (r_sat ? rpn_pkg::ST_SAT : rpn_pkg::ST_OK);
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        o_stat.op       = prog_rdata[35:32];
        o_stat.lvl_lt1  = (r_level == '0);
        o_stat.lvl_lt2  = (r_level < LW'(2));
        o_stat.lvl_full = (r_level > LW'(STACK_DEPTH));
        o_stat.pc_end   = (r_pc == PCW'(PROGRAM_DEPTH));
        o_stat.top_zero = (r_top == '0);
        o_stat.out_free = !r_out_valid || !i_out_stall;
    end

endmodule

### sv/rpn_ctrl.sv
// Evaluator sequencer: fetches and decodes tokens and steps the multicycle units.
// Depends on rpn_pkg.
module rpn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_command,
    output logic           o_in_stall,
    input  rpn_pkg::t_stat i_stat,
    output rpn_pkg::t_cmd  o_cmd
);

    typedef enum logic [15:0] {
        S_IDLE   = 16'h0001,
        S_XMUL   = 16'h0002,
        S_XADD   = 16'h0004,
        S_FETCH  = 16'h0008,
        S_DECODE = 16'h0010,
        S_BIN    = 16'h0020,
        S_MULF   = 16'h0040,
        S_DIV    = 16'h0080,
        S_DIVF   = 16'h0100,
        S_ANG1   = 16'h0200,
        S_ANG2   = 16'h0400,
        S_ANG3   = 16'h0800,
        S_ANG4   = 16'h1000,
        S_CORD   = 16'h2000,
        S_CORDF  = 16'h4000,
        S_DONE   = 16'h8000
    } t_state;

    t_state                    r_state, n_state;
    logic [rpn_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]                r_op, n_op;
    logic [2:0]                r_kind, n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_op    <= rpn_pkg::OP_PUSHX;
            r_kind  <= rpn_pkg::ST_OK;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_op    <= n_op;
            r_kind  <= n_kind;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_kind  = r_kind;
        o_cmd   = '0;
        o_cmd.iter     = r_cnt[4:0];
        o_cmd.fin_kind = r_kind;
        o_cmd.sel_sin  = (r_op == rpn_pkg::OP_SIN);
        o_cmd.push_x   = (i_stat.op == rpn_pkg::OP_PUSHX);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_command == rpn_pkg::CMD_EVAL) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_XMUL;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_XMUL: begin
                o_cmd.x_mul = 1'b1;
                n_state     = S_XADD;
            end
            S_XADD: begin
                o_cmd.x_add = 1'b1;
                n_state     = S_FETCH;
            end
            S_FETCH: begin
                if (i_stat.pc_end) begin
                    n_kind  = rpn_pkg::ST_NOSTOP;
                    n_state = S_DONE;
                end else begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_op = i_stat.op;
                case (i_stat.op)
                    rpn_pkg::OP_PUSHX, rpn_pkg::OP_PUSHC: begin
                        if (i_stat.lvl_full) begin
                            n_kind  = rpn_pkg::ST_FAULT;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.push   = 1'b1;
                            o_cmd.pc_inc = 1'b1;
                            n_state      = S_FETCH;
                        end
                    end
                    rpn_pkg::OP_ADD, rpn_pkg::OP_SUB, rpn_pkg::OP_MUL, rpn_pkg::OP_DIV: begin
                        if (i_stat.lvl_lt2) begin
                            n_kind  = rpn_pkg::ST_FAULT;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.pop = 1'b1;
                            n_state   = S_BIN;
                        end
                    end
                    rpn_pkg::OP_SIN, rpn_pkg::OP_COS: begin
                        if (i_stat.lvl_lt1) begin
                            n_kind  = rpn_pkg::ST_FAULT;
                            n_state = S_DONE;
                        end else begin
                            n_state = S_ANG1;
                        end
                    end
                    rpn_pkg::OP_STOP: begin
                        n_kind  = i_stat.lvl_lt1 ? rpn_pkg::ST_FAULT : rpn_pkg::ST_OK;
                        n_state = S_DONE;
                    end
                    default: begin
                        o_cmd.pc_inc = 1'b1;
                        n_state      = S_FETCH;
                    end
                endcase
            end
            S_BIN: begin
                case (r_op)
                    rpn_pkg::OP_ADD: begin
                        o_cmd.bin_add = 1'b1;
                        o_cmd.pc_inc  = 1'b1;
                        n_state       = S_FETCH;
                    end
                    rpn_pkg::OP_SUB: begin
                        o_cmd.bin_sub = 1'b1;
                        o_cmd.pc_inc  = 1'b1;
                        n_state       = S_FETCH;
                    end
                    rpn_pkg::OP_MUL: begin
                        o_cmd.bin_mul = 1'b1;
                        n_state       = S_MULF;
                    end
                    default: begin
                        o_cmd.bin_div = 1'b1;
                        n_cnt         = '0;
                        if (i_stat.top_zero) begin
                            o_cmd.pc_inc = 1'b1;
                            n_state      = S_FETCH;
                        end else begin
                            n_state = S_DIV;
                        end
                    end
                endcase
            end
            S_MULF: begin
                o_cmd.mul_fin = 1'b1;
                o_cmd.pc_inc  = 1'b1;
                n_state       = S_FETCH;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + rpn_pkg::CNT_W'(1);
                if (r_cnt == rpn_pkg::CNT_W'(rpn_pkg::DIV_STEPS - 1)) begin
                    n_state = S_DIVF;
                end
            end
            S_DIVF: begin
                o_cmd.div_fin = 1'b1;
                o_cmd.pc_inc  = 1'b1;
                n_state       = S_FETCH;
            end
            S_ANG1: begin
                o_cmd.ang1 = 1'b1;
                n_state    = S_ANG2;
            end
            S_ANG2: begin
                o_cmd.ang2 = 1'b1;
                n_state    = S_ANG3;
            end
            S_ANG3: begin
                o_cmd.ang3 = 1'b1;
                n_state    = S_ANG4;
            end
            S_ANG4: begin
                o_cmd.ang4 = 1'b1;
                n_cnt      = '0;
                n_state    = S_CORD;
            end
            S_CORD: begin
                o_cmd.cord_step = 1'b1;
                n_cnt           = r_cnt + rpn_pkg::CNT_W'(1);
                if (r_cnt == rpn_pkg::CNT_W'(rpn_pkg::CORDIC_STEPS - 1)) begin
                    n_state = S_CORDF;
                end
            end
            S_CORDF: begin
                o_cmd.cord_fin = 1'b1;
                o_cmd.pc_inc   = 1'b1;
                n_state        = S_FETCH;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
